>>> rtl/csg_pkg.sv
package csg_pkg;

  // Default fraction width of the segment parameter u
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Operand and result width (Q16.16)
  localparam int unsigned PW = 32;
  // Internal datapath width; Hermite intermediates need up to 37 bits
  localparam int unsigned DW = 40;

  // Register stages from input to output register
  localparam int unsigned NUM_STAGES = 10;

  typedef enum logic [1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_BEZIER  = 2'd1,
    MODE_HERMITE = 2'd2,
    MODE_EULER   = 2'd3
  } interp_mode_e;

  localparam interp_mode_e MODE_RESET = MODE_BEZIER;

  // 360 degrees in Q16.16 is 45 * 2^19: split the magnitude at bit 19 and
  // divide the upper part by 45 through a reciprocal
  localparam int unsigned ANG_LOW_BITS    = 19;
  localparam int unsigned ANG_N_BITS      = PW - ANG_LOW_BITS;
  localparam int unsigned ANG_DIV         = 45;
  localparam int unsigned ANG_RECIP       = 23301;
  localparam int unsigned ANG_RECIP_BITS  = 15;
  localparam int unsigned ANG_RECIP_SHIFT = 20;
  localparam int unsigned ANG_Q_BITS      = 7;
  localparam int unsigned ANG_REM_BITS    = 7;
  localparam int unsigned ANG_W           = 27;

  localparam logic signed [ANG_W-1:0] ANGLE_FULL = 27'sd23592960;
  localparam logic signed [ANG_W-1:0] ANGLE_HALF = 27'sd11796480;

  localparam logic signed [PW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [PW-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } csg_ctrl_t;

endpackage

>>> rtl/csg_pipe_ctrl.sv
module csg_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic                stall_i,
  output csg_pkg::csg_ctrl_t  ctrl_o
);

  localparam int unsigned N = csg_pkg::NUM_STAGES;

  logic [N-1:0] valid_q, valid_d, ready;

  // A stage loads when it is empty or its successor moves on
  always_comb begin
    ready[N-1] = !valid_q[N-1] || !stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_d[0] = ready[0] ? valid_i : valid_q[0];
    for (int k = 1; k < N; k++) begin
      valid_d[k] = ready[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign stall_o      = !ready[0];
  assign ctrl_o.load  = ready;
  assign ctrl_o.valid = valid_q;

endmodule

>>> rtl/csg_lerp.sv
module csg_lerp #(
  parameter int unsigned FRAC_BITS = csg_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             load_mul_i,
  input  logic                             load_rnd_i,
  input  logic [FRAC_BITS:0]               u_i,
  input  logic signed [csg_pkg::DW-1:0]    diff_i,
  input  logic signed [csg_pkg::DW-1:0]    base_i,
  output logic signed [csg_pkg::DW-1:0]    val_o
);

  localparam int unsigned DW = csg_pkg::DW;
  localparam int unsigned UW = FRAC_BITS + 1;
  localparam int unsigned MW = DW + UW + 1;
  localparam logic signed [MW-1:0] RND_HALF = MW'(1) << (FRAC_BITS - 1);

  logic signed [UW:0]    u_s;
  logic signed [MW-1:0]  prod_d, prod_q;
  logic signed [DW-1:0]  base_q;
  logic signed [MW-1:0]  rnd_sum, rnd_shift;
  logic signed [DW-1:0]  val_d, val_q;

  assign u_s    = $signed({1'b0, u_i});
  assign prod_d = MW'(diff_i) * MW'(u_s);

  always_ff @(posedge clk_i) begin
    if (load_mul_i) begin
      prod_q <= prod_d;
      base_q <= base_i;
    end
  end

  // round half up: floor((p + half) / 2^FRAC_BITS)
  assign rnd_sum   = prod_q + RND_HALF;
  assign rnd_shift = rnd_sum >>> FRAC_BITS;
  assign val_d     = base_q + $signed(rnd_shift[DW-1:0]);

  always_ff @(posedge clk_i) begin
    if (load_rnd_i) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

>>> rtl/csg_angle_mod.sv
module csg_angle_mod (
  input  logic                                clk_i,
  input  logic [3:0]                          load_i,
  input  logic signed [csg_pkg::PW-1:0]       angle_i,
  output logic signed [csg_pkg::ANG_W-1:0]    angle_o
);

  localparam int unsigned PW    = csg_pkg::PW;
  localparam int unsigned LB    = csg_pkg::ANG_LOW_BITS;
  localparam int unsigned NB    = csg_pkg::ANG_N_BITS;
  localparam int unsigned RB    = csg_pkg::ANG_RECIP_BITS;
  localparam int unsigned QB    = csg_pkg::ANG_Q_BITS;
  localparam int unsigned EB    = csg_pkg::ANG_REM_BITS;
  localparam int unsigned AW    = csg_pkg::ANG_W;
  localparam int unsigned PRODW = NB + RB;
  localparam int unsigned MAGW  = EB - 1 + LB;

  // magnitude split
  logic [PW-1:0]  mag;
  logic [NB-1:0]  n_a_q;
  logic [LB-1:0]  low_a_q;
  logic           neg_a_q;

  // quotient estimate, true quotient or one below
  logic [PRODW-1:0] quot_prod;
  logic [QB-1:0]    q_b_q;
  logic [NB-1:0]    n_b_q;
  logic [LB-1:0]    low_b_q;
  logic             neg_b_q;

  // remainder before correction, below twice the divisor
  logic [NB-1:0]  qmul;
  logic [NB-1:0]  rem_full;
  logic [EB-1:0]  rem_c_q;
  logic [LB-1:0]  low_c_q;
  logic           neg_c_q;

  logic [EB-1:0]        rem_corr;
  logic [MAGW-1:0]      mag_r;
  logic signed [AW-1:0] mag_ext;
  logic signed [AW-1:0] angle_d, angle_q;

  assign mag = angle_i[PW-1] ? (~angle_i + PW'(1)) : angle_i;

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      n_a_q   <= mag[PW-1:LB];
      low_a_q <= mag[LB-1:0];
      neg_a_q <= angle_i[PW-1];
    end
  end

  assign quot_prod = PRODW'(n_a_q) * PRODW'(csg_pkg::ANG_RECIP);

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      q_b_q   <= quot_prod[csg_pkg::ANG_RECIP_SHIFT +: QB];
      n_b_q   <= n_a_q;
      low_b_q <= low_a_q;
      neg_b_q <= neg_a_q;
    end
  end

  assign qmul     = NB'(q_b_q) * NB'(csg_pkg::ANG_DIV);
  assign rem_full = n_b_q - qmul;

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      rem_c_q <= rem_full[EB-1:0];
      low_c_q <= low_b_q;
      neg_c_q <= neg_b_q;
    end
  end

  // one correction step, then restore the dividend's sign
  assign rem_corr = (rem_c_q >= EB'(csg_pkg::ANG_DIV)) ?
                    (rem_c_q - EB'(csg_pkg::ANG_DIV)) : rem_c_q;
  assign mag_r    = {rem_corr[EB-2:0], low_c_q};
  assign mag_ext  = $signed(AW'(mag_r));
  assign angle_d  = neg_c_q ? -mag_ext : mag_ext;

  always_ff @(posedge clk_i) begin
    if (load_i[3]) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule

>>> rtl/cubic_segment_evaluator.sv
// Each request passes through the register stages of the stage map below, from the front stage
// to the output register. Throughput: one request per cycle while out_stall_i is low.
// Every stage holds while its successor is stalled; empty stages fill so bubbles collapse.
// Depth: three lerp levels (difference, multiply, round-add each) plus saturation.
// Reset: asynchronous, active low; clears all stage valid bits and sets
// interp_mode to cubic Bezier. Datapath registers are not reset.
module cubic_segment_evaluator #(
  parameter int unsigned FRAC_BITS = csg_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // configuration write channel (interp_mode)
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_data_i,

  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [FRAC_BITS:0]                frac_i,
  input  logic signed [csg_pkg::PW-1:0]     point_a_i,
  input  logic signed [csg_pkg::PW-1:0]     point_b_i,
  input  logic signed [csg_pkg::PW-1:0]     point_c_i,
  input  logic signed [csg_pkg::PW-1:0]     point_d_i,

  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [csg_pkg::PW-1:0]     value_o,
  output logic                              saturated_o
);

  localparam int unsigned DW = csg_pkg::DW;
  localparam int unsigned PW = csg_pkg::PW;
  localparam int unsigned AW = csg_pkg::ANG_W;
  localparam int unsigned UW = FRAC_BITS + 1;
  localparam logic [UW-1:0] U_ONE = UW'(1) << FRAC_BITS;

  // Stage map (register bank index):
  //   0  front: clamp u, first-level differences, Hermite coefficients,
  //      angle magnitude split
  //   1  level-1 products          | angle quotient estimate
  //   2  level-1 round-add         | angle remainder
  //   3  level-2 differences       | angle correction and sign
  //   4  level-2 products          | shorter-way adjust of the second angle
  //   5  level-2 round-add
  //   6  level-3 difference, chosen by mode
  //   7  level-3 product
  //   8  level-3 round-add
  //   9  saturation, output register
  // Linear and Euler use only level 3; Hermite runs its Horner steps through
  // lane 0 of each level; Bezier is de Casteljau across all three levels.

  csg_pkg::csg_ctrl_t ctrl;

  csg_pipe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .stall_i (out_stall_i),
    .ctrl_o  (ctrl)
  );

  // ---------------------------------------------------------------------
  // Mode register (no enforcement in the block): the user must make writes only while the pipeline is idle
  // ---------------------------------------------------------------------
  csg_pkg::interp_mode_e cfg_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q <= csg_pkg::MODE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_mode_q <= csg_pkg::interp_mode_e'(cfg_data_i);
    end
  end

  // ---------------------------------------------------------------------
  // Front stage
  // ---------------------------------------------------------------------
  logic [UW-1:0]        u_in;
  logic signed [DW-1:0] a_x, b_x, c_x, d_x;
  logic signed [DW-1:0] dab, dbc, dcd, c2, c3;
  logic signed [DW-1:0] l1_diff_d [0:2];
  logic signed [DW-1:0] l1_base_d [0:2];

  // u above one clamps to one
  assign u_in = (frac_i > U_ONE) ? U_ONE : frac_i;

  assign a_x = DW'(point_a_i);
  assign b_x = DW'(point_b_i);
  assign c_x = DW'(point_c_i);
  assign d_x = DW'(point_d_i);

  assign dab = b_x - a_x;
  assign dbc = c_x - b_x;
  assign dcd = d_x - c_x;

  // c3 = 2(p0 - p1) + q0 + q1, c2 = 3(p1 - p0) - 2 q0 - q1
  assign c3 = c_x + d_x - (dab <<< 1);
  assign c2 = (dab <<< 1) + dab - (c_x <<< 1) - d_x;

  always_comb begin
    if (cfg_mode_q == csg_pkg::MODE_HERMITE) begin
      l1_diff_d[0] = c3;
      l1_base_d[0] = c2;
    end else begin
      l1_diff_d[0] = dab;
      l1_base_d[0] = a_x;
    end
    l1_diff_d[1] = dbc;
    l1_base_d[1] = b_x;
    l1_diff_d[2] = dcd;
    l1_base_d[2] = c_x;
  end

  logic signed [DW-1:0] l1_diff_q [0:2];
  logic signed [DW-1:0] l1_base_q [0:2];

  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      for (int i = 0; i < 3; i++) begin
        l1_diff_q[i] <= l1_diff_d[i];
        l1_base_q[i] <= l1_base_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Side data that travels with each request
  // ---------------------------------------------------------------------
  csg_pkg::interp_mode_e mode_q [0:5];
  logic [UW-1:0]         u_q    [0:6];
  logic signed [DW-1:0]  pa_q   [0:5];
  logic signed [DW-1:0]  pb_q   [0:5];
  logic signed [DW-1:0]  pc_q   [0:2];

  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      mode_q[0] <= cfg_mode_q;
      u_q[0]    <= u_in;
      pa_q[0]   <= a_x;
      pb_q[0]   <= b_x;
      pc_q[0]   <= c_x;
    end
    for (int k = 1; k < 6; k++) begin
      if (ctrl.load[k]) begin
        mode_q[k] <= mode_q[k-1];
        pa_q[k]   <= pa_q[k-1];
        pb_q[k]   <= pb_q[k-1];
      end
    end
    for (int k = 1; k < 7; k++) begin
      if (ctrl.load[k]) begin
        u_q[k] <= u_q[k-1];
      end
    end
    for (int k = 1; k < 3; k++) begin
      if (ctrl.load[k]) begin
        pc_q[k] <= pc_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Level 1: three lanes (Bezier), lane 0 alone for Hermite
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] l1_val [0:2];

  for (genvar i = 0; i < 3; i++) begin : g_l1
    csg_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
      .clk_i      (clk_i),
      .load_mul_i (ctrl.load[1]),
      .load_rnd_i (ctrl.load[2]),
      .u_i        (u_q[0]),
      .diff_i     (l1_diff_q[i]),
      .base_i     (l1_base_q[i]),
      .val_o      (l1_val[i])
    );
  end

  // ---------------------------------------------------------------------
  // Level 2 differences
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] l2_diff_d [0:1];
  logic signed [DW-1:0] l2_base_d [0:1];
  logic signed [DW-1:0] l2_diff_q [0:1];
  logic signed [DW-1:0] l2_base_q [0:1];

  always_comb begin
    if (mode_q[2] == csg_pkg::MODE_HERMITE) begin
      // next Horner step: q0 + u * t
      l2_diff_d[0] = l1_val[0];
      l2_base_d[0] = pc_q[2];
    end else begin
      l2_diff_d[0] = l1_val[1] - l1_val[0];
      l2_base_d[0] = l1_val[0];
    end
    l2_diff_d[1] = l1_val[2] - l1_val[1];
    l2_base_d[1] = l1_val[1];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[3]) begin
      for (int i = 0; i < 2; i++) begin
        l2_diff_q[i] <= l2_diff_d[i];
        l2_base_q[i] <= l2_base_d[i];
      end
    end
  end

  logic signed [DW-1:0] l2_val [0:1];

  for (genvar i = 0; i < 2; i++) begin : g_l2
    csg_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
      .clk_i      (clk_i),
      .load_mul_i (ctrl.load[4]),
      .load_rnd_i (ctrl.load[5]),
      .u_i        (u_q[3]),
      .diff_i     (l2_diff_q[i]),
      .base_i     (l2_base_q[i]),
      .val_o      (l2_val[i])
    );
  end

  // ---------------------------------------------------------------------
  // Euler angles: truncating remainder modulo 360 degrees, keeps the sign
  // of the dividend; runs beside levels 1 and 2
  // ---------------------------------------------------------------------
  logic signed [AW-1:0] ang0, ang1;

  csg_angle_mod u_ang0 (
    .clk_i   (clk_i),
    .load_i  (ctrl.load[3:0]),
    .angle_i (point_a_i),
    .angle_o (ang0)
  );

  csg_angle_mod u_ang1 (
    .clk_i   (clk_i),
    .load_i  (ctrl.load[3:0]),
    .angle_i (point_b_i),
    .angle_o (ang1)
  );

  // Move the second angle by a full turn when the other way is shorter
  logic signed [AW-1:0] k1_adj;
  logic signed [AW-1:0] ek0_q [0:1];
  logic signed [AW-1:0] ek1_q [0:1];

  always_comb begin
    priority if (ang0 - ang1 > csg_pkg::ANGLE_HALF) begin
      k1_adj = ang1 + csg_pkg::ANGLE_FULL;
    end else if (ang1 - ang0 > csg_pkg::ANGLE_HALF) begin
      k1_adj = ang1 - csg_pkg::ANGLE_FULL;
    end else begin
      k1_adj = ang1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[4]) begin
      ek0_q[0] <= ang0;
      ek1_q[0] <= k1_adj;
    end
    if (ctrl.load[5]) begin
      ek0_q[1] <= ek0_q[0];
      ek1_q[1] <= ek1_q[0];
    end
  end

  // ---------------------------------------------------------------------
  // Level 3 difference, one subtractor shared by all modes
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] l3_min, l3_sub, l3_base_d;
  logic signed [DW-1:0] l3_diff_q, l3_base_q;

  always_comb begin
    unique case (mode_q[5])
      csg_pkg::MODE_LINEAR: begin
        l3_min    = pb_q[5];
        l3_sub    = pa_q[5];
        l3_base_d = pa_q[5];
      end
      csg_pkg::MODE_BEZIER: begin
        l3_min    = l2_val[1];
        l3_sub    = l2_val[0];
        l3_base_d = l2_val[0];
      end
      csg_pkg::MODE_HERMITE: begin
        // last Horner step: p0 + u * t
        l3_min    = l2_val[0];
        l3_sub    = '0;
        l3_base_d = pa_q[5];
      end
      csg_pkg::MODE_EULER: begin
        l3_min    = DW'(ek1_q[1]);
        l3_sub    = DW'(ek0_q[1]);
        l3_base_d = DW'(ek0_q[1]);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[6]) begin
      l3_diff_q <= l3_min - l3_sub;
      l3_base_q <= l3_base_d;
    end
  end

  logic signed [DW-1:0] l3_val;

  csg_lerp #(.FRAC_BITS(FRAC_BITS)) u_l3 (
    .clk_i      (clk_i),
    .load_mul_i (ctrl.load[7]),
    .load_rnd_i (ctrl.load[8]),
    .u_i        (u_q[6]),
    .diff_i     (l3_diff_q),
    .base_i     (l3_base_q),
    .val_o      (l3_val)
  );

  // ---------------------------------------------------------------------
  // Saturate to 32 bits; only Hermite can leave the range
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] value_d, value_q;
  logic                 sat_d, sat_q;

  always_comb begin
    priority if (l3_val > DW'(csg_pkg::VAL_MAX)) begin
      value_d = csg_pkg::VAL_MAX;
      sat_d   = 1'b1;
    end else if (l3_val < DW'(csg_pkg::VAL_MIN)) begin
      value_d = csg_pkg::VAL_MIN;
      sat_d   = 1'b1;
    end else begin
      value_d = l3_val[PW-1:0];
      sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[9]) begin
      value_q <= value_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o = ctrl.valid[csg_pkg::NUM_STAGES-1];
  assign value_o     = value_q;
  assign saturated_o = sat_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Back-pressure reaches the input only when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&ctrl.valid))
    else $error("input stalled while a pipeline stage is empty");

  a_u_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.valid[0] |-> (u_q[0] <= U_ONE))
    else $error("segment parameter above one after clamp");

  a_ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.valid[3] |-> ((ang0 < csg_pkg::ANGLE_FULL) && (ang0 > -csg_pkg::ANGLE_FULL) &&
                       (ang1 < csg_pkg::ANGLE_FULL) && (ang1 > -csg_pkg::ANGLE_FULL)))
    else $error("reduced angle outside one full turn");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      ((value_o == csg_pkg::VAL_MAX) || (value_o == csg_pkg::VAL_MIN)))
    else $error("saturation flag without a rail value");

endmodule
